@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the thermostat relay control.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define TSRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define TSRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/tsrc_pkg.sv @@
// ---------------------------------------------------------------------------
// Thermostat relay control package
// Payload types, register map, call codes and wiring mode codes.
// ---------------------------------------------------------------------------
package tsrc_pkg;

  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [2:0] {
    REG_DAY_SETPOINT   = 3'd0,
    REG_NIGHT_SETPOINT = 3'd1,
    REG_DEAD_BAND      = 3'd2,
    REG_WIRING_MODE    = 3'd3,
    REG_TEMP_SOURCE    = 3'd4,
    REG_MODULE_ROLE    = 3'd5,
    REG_DAY_START      = 3'd6,
    REG_DAY_END        = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    CALL_IDLE = 2'd0,
    CALL_COOL = 2'd1,
    CALL_HEAT = 2'd2
  } call_t;

  localparam logic [1:0] WIRING_CONV   = 2'd0;
  localparam logic [1:0] WIRING_MODE_O = 2'd1;
  localparam logic [1:0] WIRING_MODE_B = 2'd2;
  localparam logic [1:0] WIRING_UNUSED = 2'd3;

  localparam logic       SRC_REMOTE   = 1'b0;
  localparam logic       SRC_LOCAL    = 1'b1;
  localparam logic       ROLE_SLAVE   = 1'b0;
  localparam logic       ROLE_MASTER  = 1'b1;
  localparam logic       CMD_MASTER_SP = 1'b1;

  localparam logic signed [15:0] DaySetpointRst   = 16'sd250;
  localparam logic signed [15:0] NightSetpointRst = 16'sd250;
  localparam logic [7:0]         DeadBandRst      = 8'd10;
  localparam logic [12:0]        DayStartRst      = 13'd1792;
  localparam logic [12:0]        DayEndRst        = 13'd4864;

  localparam logic signed [15:0] LocalTempMin  = -16'sd20;
  localparam logic [32:0]        StageDelay    = 33'd300;
  localparam logic signed [16:0] StageTempTol  = 17'sd10;
  localparam logic [16:0]        SecPerHour    = 17'd3600;
  localparam logic [16:0]        SecPerMinute  = 17'd60;

  typedef struct packed {
    logic [4:0]         clock_hour;
    logic [5:0]         clock_minute;
    logic [5:0]         clock_second;
    logic [31:0]        run_seconds;
    logic signed [15:0] remote_temp;
    logic               remote_temp_valid;
    logic signed [15:0] local_temp;
    logic               command_enable;
    logic               command_type;
    logic signed [15:0] master_setpoint;
    logic               master_setpoint_valid;
    logic               link_connected;
  } tsrc_in_t;

  typedef struct packed {
    logic       relay_w;
    logic       relay_y;
    logic       relay_g;
    logic       relay_heat2;
    logic       relay_cool2;
    logic [1:0] call_state;
    logic [1:0] stage_now;
    logic       is_day;
  } tsrc_out_t;

endpackage

@@ src/thermostat_stage_relay_control.sv @@
// ---------------------------------------------------------------------------
// Thermostat stage relay control
// Two-stage heat/cool call with deadband, stage timing and relay wiring.
// ---------------------------------------------------------------------------
// Usage:
// Each transaction on the in_ channel is one control tick: time of day, the
// run-seconds count, temperatures, the master command and link status. For
// every tick the out_ channel delivers one transaction with the five relay
// drives, the reported call, the current stage and the day flag.
// A tick is registered in the input register on acceptance and evaluated
// from there against the held call, stage and mark state; its result is then
// written to the output register, and out_valid rises with that load.
// Throughput is one tick per cycle while the receiver does not stall; the only
// loop is the update of the call and stage state at the output register load.
// When the receiver stalls, one result waits in the output register and one
// more tick is held in the input register; in_stall rises only when both are
// full.
// Setpoints, deadband, wiring, source, role and the day window are written
// through the APB-style cfg_ port (register i at byte address 4*i). The user
// must write them only while no tick is in flight; the block does not enforce it.
// Synchronous reset clears both pipeline registers, sets the call to idle,
// the stage to 1, the marks to zero and all registers to their defaults.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module thermostat_stage_relay_control
  import tsrc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tsrc_in_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tsrc_out_t           out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  logic signed [15:0] day_setpoint_r;
  logic signed [15:0] night_setpoint_r;
  logic [7:0]         dead_band_r;
  logic [1:0]         wiring_mode_r;
  logic               temp_source_r;
  logic               module_role_r;
  logic [12:0]        day_start_r;
  logic [12:0]        day_end_r;

  logic               s1_valid_r;
  tsrc_in_t           s1_data_r;
  logic               out_valid_r;
  tsrc_out_t          out_data_r;
  tsrc_out_t          out_data_nxt;

  call_t              last_call_r;
  call_t              last_call_nxt;
  logic [1:0]         stage_r;
  logic [1:0]         stage_nxt;
  logic [31:0]        mark_time_r;
  logic [31:0]        mark_time_nxt;
  logic signed [15:0] mark_temp_r;
  logic signed [15:0] mark_temp_nxt;

  logic               cfg_wr;
  reg_idx_t           cfg_idx;
  logic               out_load;

  logic [16:0]        now_sec;
  logic [16:0]        start_sec;
  logic [16:0]        end_sec;
  logic               day;
  logic               slave;
  logic               data_ok;
  logic               active;
  logic signed [15:0] temp;
  logic signed [15:0] point;
  logic signed [17:0] band_lo;
  logic signed [17:0] band_hi;
  call_t              call;
  logic               call_chg;
  logic [31:0]        eff_mark_time;
  logic signed [15:0] eff_mark_temp;
  logic signed [16:0] temp_diff;
  logic               stage_up;
  logic [4:0]         relays;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[CfgAddrW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_setpoint_r   <= DaySetpointRst;
      night_setpoint_r <= NightSetpointRst;
      dead_band_r      <= DeadBandRst;
      wiring_mode_r    <= WIRING_CONV;
      temp_source_r    <= SRC_REMOTE;
      module_role_r    <= ROLE_SLAVE;
      day_start_r      <= DayStartRst;
      day_end_r        <= DayEndRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DAY_SETPOINT:   day_setpoint_r   <= pwdata[15:0];
        REG_NIGHT_SETPOINT: night_setpoint_r <= pwdata[15:0];
        REG_DEAD_BAND:      dead_band_r      <= pwdata[7:0];
        REG_WIRING_MODE:    wiring_mode_r    <= pwdata[1:0];
        REG_TEMP_SOURCE:    temp_source_r    <= pwdata[0];
        REG_MODULE_ROLE:    module_role_r    <= pwdata[0];
        REG_DAY_START:      day_start_r      <= pwdata[12:0];
        REG_DAY_END:        day_end_r        <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DAY_SETPOINT:   prdata = CfgDataW'(signed'(day_setpoint_r));
      REG_NIGHT_SETPOINT: prdata = CfgDataW'(signed'(night_setpoint_r));
      REG_DEAD_BAND:      prdata = CfgDataW'(dead_band_r);
      REG_WIRING_MODE:    prdata = CfgDataW'(wiring_mode_r);
      REG_TEMP_SOURCE:    prdata = CfgDataW'(temp_source_r);
      REG_MODULE_ROLE:    prdata = CfgDataW'(module_role_r);
      REG_DAY_START:      prdata = CfgDataW'(day_start_r);
      REG_DAY_END:        prdata = CfgDataW'(day_end_r);
      default:            prdata = '0;
    endcase
  end

  assign out_load = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data_r <= in_data;
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign now_sec   = 17'(s1_data_r.clock_hour) * SecPerHour
                   + 17'(s1_data_r.clock_minute) * SecPerMinute
                   + 17'(s1_data_r.clock_second);
  assign start_sec = 17'(day_start_r[12:8]) * SecPerHour + 17'(day_start_r[7:0]) * SecPerMinute;
  assign end_sec   = 17'(day_end_r[12:8]) * SecPerHour + 17'(day_end_r[7:0]) * SecPerMinute;

  always_comb begin
    if (end_sec > start_sec) begin
      day = (now_sec > start_sec) && (now_sec <= end_sec);
    end else begin
      day = !((now_sec > start_sec) || (now_sec <= end_sec));
    end
  end

  assign slave = (module_role_r == ROLE_SLAVE);

  always_comb begin
    data_ok = 1'b1;
    if (temp_source_r == SRC_REMOTE) begin
      temp = s1_data_r.remote_temp;
      if (!s1_data_r.remote_temp_valid) data_ok = 1'b0;
    end else begin
      temp = s1_data_r.local_temp;
      if (s1_data_r.local_temp <= LocalTempMin) data_ok = 1'b0;
    end
    if (slave && s1_data_r.command_type == CMD_MASTER_SP) begin
      point = s1_data_r.master_setpoint;
      if (!s1_data_r.master_setpoint_valid) data_ok = 1'b0;
    end else begin
      point = day ? day_setpoint_r : night_setpoint_r;
    end
  end

  assign active  = data_ok && !(slave && !s1_data_r.command_enable);
  assign band_hi = 18'(point) + signed'({10'd0, dead_band_r});
  assign band_lo = (18'(point) > signed'({10'd0, dead_band_r}))
                 ? 18'(point) - signed'({10'd0, dead_band_r}) : 18'sd0;

  always_comb begin
    if (18'(temp) > band_hi) begin
      call = CALL_COOL;
    end else if (18'(temp) < band_lo) begin
      call = CALL_HEAT;
    end else begin
      call = CALL_IDLE;
    end
  end

  assign call_chg      = (call != last_call_r);
  assign eff_mark_time = call_chg ? s1_data_r.run_seconds : mark_time_r;
  assign eff_mark_temp = call_chg ? temp : mark_temp_r;
  assign temp_diff     = 17'(temp) - 17'(eff_mark_temp);
  assign stage_up      = ({1'b0, s1_data_r.run_seconds} > ({1'b0, eff_mark_time} + StageDelay))
                      && (temp_diff >= -StageTempTol) && (temp_diff <= StageTempTol);

  always_comb begin
    last_call_nxt = last_call_r;
    stage_nxt     = stage_r;
    mark_time_nxt = mark_time_r;
    mark_temp_nxt = mark_temp_r;
    if (active) begin
      last_call_nxt = call;
      mark_time_nxt = eff_mark_time;
      mark_temp_nxt = eff_mark_temp;
      if (stage_up) begin
        stage_nxt = 2'd2;
      end else if (call_chg) begin
        stage_nxt = 2'd1;
      end
    end
  end

  always_comb begin
    relays = '0;
    if (wiring_mode_r != WIRING_UNUSED) begin
      case (call)
        CALL_COOL: begin
          relays[1] = 1'b1;
          relays[2] = 1'b1;
          relays[0] = (wiring_mode_r == WIRING_MODE_O);
          relays[4] = (stage_nxt == 2'd2);
        end
        CALL_HEAT: begin
          relays[2] = 1'b1;
          relays[0] = (wiring_mode_r == WIRING_CONV) || (wiring_mode_r == WIRING_MODE_B);
          relays[1] = (wiring_mode_r == WIRING_MODE_O) || (wiring_mode_r == WIRING_MODE_B);
          relays[3] = (stage_nxt == 2'd2);
        end
        default: relays = '0;
      endcase
    end
  end

  always_comb begin
    out_data_nxt            = '0;
    out_data_nxt.stage_now  = stage_nxt;
    out_data_nxt.is_day     = day;
    if (active && !(slave && !s1_data_r.link_connected)) begin
      out_data_nxt.call_state  = call;
      out_data_nxt.relay_w     = relays[0];
      out_data_nxt.relay_y     = relays[1];
      out_data_nxt.relay_g     = relays[2];
      out_data_nxt.relay_heat2 = relays[3];
      out_data_nxt.relay_cool2 = relays[4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_call_r <= CALL_IDLE;
      stage_r     <= 2'd1;
      mark_time_r <= '0;
      mark_temp_r <= '0;
    end else if (out_load) begin
      last_call_r <= last_call_nxt;
      stage_r     <= stage_nxt;
      mark_time_r <= mark_time_nxt;
      mark_temp_r <= mark_temp_nxt;
    end
  end

  `TSRC_ASSERT(a_stage_range, stage_r == 2'd1 || stage_r == 2'd2, "stage out of range")
  `TSRC_ASSERT(a_call_change_restarts, out_load && active && call_chg |=> stage_r == 2'd1 && mark_time_r == $past(s1_data_r.run_seconds), "call change did not restart stage")
  `TSRC_ASSERT(a_fan_needs_call, out_valid_r && out_data_r.relay_g |-> out_data_r.call_state != CALL_IDLE, "fan on with idle call")
  `TSRC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !s1_valid_r && !out_valid_r, "pipeline not empty after reset")

endmodule

@@ verif/tb_thermostat_stage_relay_control.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Thermostat stage relay control testbench
// Sends control ticks through the in_ channel under several register
// settings written over the APB-style port. Each accepted tick is run
// through a local predictor of the call, stage and relay logic, and every
// result transaction is compared field by field with the oldest prediction.
// Both sides idle at random, except during one phase that runs back to back.
// ---------------------------------------------------------------------------
module tb_thermostat_stage_relay_control;
  import tsrc_pkg::*;

  localparam int IdlePct      = 17;
  localparam int QuietLimit   = 5000;
  localparam int RandPhases   = 10;
  localparam int TicksPerPhase = 70;
  localparam logic [1:0] StageOne     = 2'd1;
  localparam logic [1:0] StageTwo     = 2'd2;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  tsrc_in_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  tsrc_out_t           out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  thermostat_stage_relay_control u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #1 clk = ~clk;

  // Register copies.
  logic signed [15:0] day_sp = DaySetpointRst;
  logic signed [15:0] night_sp = NightSetpointRst;
  logic [7:0]         band = DeadBandRst;
  logic [1:0]         wiring = WIRING_CONV;
  logic               src_sel = SRC_REMOTE;
  logic               role = ROLE_SLAVE;
  logic [12:0]        win_start = DayStartRst;
  logic [12:0]        win_end = DayEndRst;

  // Call and stage state.
  call_t              held_call = CALL_IDLE;
  logic [1:0]         held_stage = StageOne;
  logic [31:0]        mark_run = '0;
  logic signed [15:0] mark_deg = '0;

  tsrc_in_t  tick_q[$];
  tsrc_out_t relay_expect_q[$];
  tsrc_out_t want;
  bit        steady = 1'b0;
  int        n_ticks = 0;
  int        n_results = 0;
  int        n_cool = 0;
  int        n_heat = 0;
  int        n_stage2 = 0;
  int        n_fail = 0;
  int        quiet_cycles = 0;

  function automatic int hm_to_sec(logic [12:0] r);
    return int'(r[12:8]) * 3600 + int'(r[7:0]) * 60;
  endfunction

  function automatic bit in_day_window(int now);
    int s, e;
    s = hm_to_sec(win_start);
    e = hm_to_sec(win_end);
    if (e > s) return (now > s) && (now <= e);
    return !((now > s) || (now <= e));
  endfunction

  // Bit order: W, Y, G, W2, Y2 from bit 0 upward.
  function automatic logic [4:0] relay_bits(call_t c, logic [1:0] st, logic [1:0] m);
    logic [4:0] r;
    r = '0;
    if (m == WIRING_UNUSED) return '0;
    case (c)
      CALL_COOL: begin
        r[1] = 1'b1;
        r[2] = 1'b1;
        if (m == WIRING_MODE_O) r[0] = 1'b1;
        if (st == StageTwo) r[4] = 1'b1;
      end
      CALL_HEAT: begin
        r[2] = 1'b1;
        if (m == WIRING_CONV) begin
          r[0] = 1'b1;
        end else if (m == WIRING_MODE_O) begin
          r[1] = 1'b1;
        end else begin
          r[0] = 1'b1;
          r[1] = 1'b1;
        end
        if (st == StageTwo) r[3] = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic tsrc_out_t eval_tick(tsrc_in_t t);
    tsrc_out_t  r;
    bit         slave, day, ok;
    int         now, temp, point, db, lo, hi, diff;
    call_t      c;
    logic [4:0] rl;
    r = '0;
    slave = (role == ROLE_SLAVE);
    now = int'(t.clock_hour) * 3600 + int'(t.clock_minute) * 60 + int'(t.clock_second);
    day = in_day_window(now);
    ok = 1'b1;
    if (src_sel == SRC_REMOTE) begin
      temp = int'($signed(t.remote_temp));
      ok = t.remote_temp_valid;
    end else begin
      temp = int'($signed(t.local_temp));
      if (temp <= int'(LocalTempMin)) ok = 1'b0;
    end
    if (slave && t.command_type == CMD_MASTER_SP) begin
      point = int'($signed(t.master_setpoint));
      if (!t.master_setpoint_valid) ok = 1'b0;
    end else begin
      point = day ? int'(day_sp) : int'(night_sp);
    end
    if (ok && !(slave && !t.command_enable)) begin
      db = int'(band);
      lo = (point > db) ? point - db : 0;
      hi = point + db;
      if (temp > hi) c = CALL_COOL;
      else if (temp < lo) c = CALL_HEAT;
      else c = CALL_IDLE;
      if (c != held_call) begin
        mark_run = t.run_seconds;
        mark_deg = temp[15:0];
        held_stage = StageOne;
        held_call = c;
      end
      diff = temp - int'(mark_deg);
      if (diff < 0) diff = -diff;
      if ({32'd0, t.run_seconds} > {32'd0, mark_run} + 64'd300 && diff <= 10)
        held_stage = StageTwo;
      if (!(slave && !t.link_connected)) begin
        r.call_state = c;
        rl = relay_bits(c, held_stage, wiring);
        {r.relay_cool2, r.relay_heat2, r.relay_g, r.relay_y, r.relay_w} = rl;
      end
    end
    r.stage_now = held_stage;
    r.is_day = day;
    return r;
  endfunction

  function automatic int sat16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic tsrc_in_t tick_of(int hr, int mn, int sc, logic [31:0] run, int rt,
                                       bit rv, int lt, bit en, bit ct, int msp, bit mv,
                                       bit lk);
    tsrc_in_t t;
    t.clock_hour = hr[4:0];
    t.clock_minute = mn[5:0];
    t.clock_second = sc[5:0];
    t.run_seconds = run;
    t.remote_temp = rt[15:0];
    t.remote_temp_valid = rv;
    t.local_temp = lt[15:0];
    t.command_enable = en;
    t.command_type = ct;
    t.master_setpoint = msp[15:0];
    t.master_setpoint_valid = mv;
    t.link_connected = lk;
    return t;
  endfunction

  task automatic cmp_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      n_fail++;
    end
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_DAY_SETPOINT:   day_sp = v[15:0];
      REG_NIGHT_SETPOINT: night_sp = v[15:0];
      REG_DEAD_BAND:      band = v[7:0];
      REG_WIRING_MODE:    wiring = v[1:0];
      REG_TEMP_SOURCE:    src_sel = v[0];
      REG_MODULE_ROLE:    role = v[0];
      REG_DAY_START:      win_start = v[12:0];
      REG_DAY_END:        win_end = v[12:0];
      default: ;
    endcase
  endtask

  task automatic load_config(logic [15:0] dsp, logic [15:0] nsp, logic [7:0] db,
                             logic [1:0] wm, logic src, logic rl, logic [12:0] ws,
                             logic [12:0] we);
    write_reg(REG_DAY_SETPOINT, {{16{dsp[15]}}, dsp});
    write_reg(REG_NIGHT_SETPOINT, {{16{nsp[15]}}, nsp});
    write_reg(REG_DEAD_BAND, {24'd0, db});
    write_reg(REG_WIRING_MODE, {30'd0, wm});
    write_reg(REG_TEMP_SOURCE, {31'd0, src});
    write_reg(REG_MODULE_ROLE, {31'd0, rl});
    write_reg(REG_DAY_START, {19'd0, ws});
    write_reg(REG_DAY_END, {19'd0, we});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Returns at a rising edge once every queued tick has produced its result.
  task automatic settle();
    do @(negedge clk);
    while (tick_q.size() != 0 || in_valid || relay_expect_q.size() != 0);
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        relay_expect_q.push_back(eval_tick(in_data));
        n_ticks++;
      end
      if (!in_valid || !in_stall) begin
        if (tick_q.size() != 0 && (steady || $urandom_range(99) >= IdlePct)) begin
          in_data <= tick_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < IdlePct);
      if (out_valid && !out_stall) begin
        n_results++;
        if (relay_expect_q.size() == 0) begin
          $error("result transaction with no tick outstanding: %p", out_data);
          n_fail++;
        end else begin
          want = relay_expect_q.pop_front();
          cmp_field("relay_w", want.relay_w, out_data.relay_w);
          cmp_field("relay_y", want.relay_y, out_data.relay_y);
          cmp_field("relay_g", want.relay_g, out_data.relay_g);
          cmp_field("relay_heat2", want.relay_heat2, out_data.relay_heat2);
          cmp_field("relay_cool2", want.relay_cool2, out_data.relay_cool2);
          cmp_field("call_state", want.call_state, out_data.call_state);
          cmp_field("stage_now", want.stage_now, out_data.stage_now);
          cmp_field("is_day", want.is_day, out_data.is_day);
          if (want.call_state == CALL_COOL) n_cool++;
          if (want.call_state == CALL_HEAT) n_heat++;
          if (want.stage_now == StageTwo) n_stage2++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || psel || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("thermostat_stage_relay_control verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0]  run_ctr;
    logic [127:0] noise;
    logic [15:0]  dsp, nsp;
    logic [7:0]   db;
    logic [1:0]   wm;
    logic [12:0]  ws, we, wtmp;
    int           ph, n, k, seg, hr, base, span, aim, tv;
    bit           cmd_sp;

    run_ctr = 32'd5000;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default settings: invalid data, stage timing, link loss, disable, master setpoint.
    load_config(16'sd250, 16'sd250, 8'd10, WIRING_CONV, SRC_REMOTE, ROLE_SLAVE,
                DayStartRst, DayEndRst);
    tick_q.push_back(tick_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    tick_q.push_back(tick_of(12, 0, 0, 1000, 300, 1, 0, 1, 0, 0, 0, 1));
    tick_q.push_back(tick_of(12, 0, 1, 1300, 305, 1, 0, 1, 0, 0, 0, 1));
    tick_q.push_back(tick_of(12, 0, 2, 1301, 310, 1, 0, 1, 0, 0, 0, 1));
    tick_q.push_back(tick_of(12, 0, 3, 1400, 311, 1, 0, 1, 0, 0, 0, 1));
    tick_q.push_back(tick_of(19, 0, 0, 2000, 100, 1, 0, 1, 0, 0, 0, 1));
    tick_q.push_back(tick_of(19, 0, 1, 2400, 95, 1, 0, 1, 0, 0, 0, 0));
    tick_q.push_back(tick_of(7, 0, 0, 2500, 95, 1, 0, 0, 0, 0, 0, 1));
    tick_q.push_back(tick_of(12, 30, 0, 2600, 95, 1, 0, 1, 1, 250, 0, 1));
    tick_q.push_back(tick_of(12, 30, 1, 3000, 100, 1, 0, 1, 1, -32768, 1, 1));
    tick_q.push_back(tick_of(12, 30, 2, 3500, 32767, 1, 0, 1, 1, 32767, 1, 1));
    tick_q.push_back(tick_of(12, 30, 3, 32'hFFFF_FFFF, -32768, 1, 0, 1, 1, 32767, 1, 1));
    tick_q.push_back(tick_of(12, 30, 4, 32'hFFFF_FFFF, -32768, 1, 0, 1, 1, 32767, 1, 1));
    tick_q.push_back(tick_of(31, 63, 63, 32'hFFFF_FFFF, -32768, 1, 32767, 1, 0, 0, 1, 1));
    tick_q.push_back(tick_of(23, 59, 59, 0, 250, 1, -32768, 1, 0, -1, 1, 1));
    settle();

    // Local thermistor, mode O, extreme setpoints, zero band, wrapped window.
    load_config(16'sd32767, 16'h8000, 8'd0, WIRING_MODE_O, SRC_LOCAL, ROLE_SLAVE,
                13'd5947, 13'd0);
    tick_q.push_back(tick_of(12, 0, 0, 100, 0, 1, -20, 1, 0, 0, 0, 1));
    tick_q.push_back(tick_of(12, 0, 1, 200, 0, 0, -19, 1, 0, 0, 0, 1));
    tick_q.push_back(tick_of(12, 0, 2, 300, 0, 0, 32767, 1, 0, 0, 0, 1));
    tick_q.push_back(tick_of(0, 0, 0, 400, 0, 0, 100, 1, 0, 0, 0, 1));
    settle();

    // Standalone master ignores command, link and master setpoint; mode B, widest band.
    load_config(16'sd250, 16'sd250, 8'd255, WIRING_MODE_B, SRC_REMOTE, ROLE_MASTER,
                13'h1FFF, 13'h1FFF);
    tick_q.push_back(tick_of(10, 0, 0, 500, -5, 1, 0, 0, 1, 0, 0, 0));
    tick_q.push_back(tick_of(10, 0, 1, 600, 506, 1, 0, 0, 1, 0, 0, 0));
    tick_q.push_back(tick_of(10, 0, 2, 700, 505, 1, 0, 0, 1, 0, 0, 0));
    settle();

    // Unused wiring code drives every relay off.
    load_config(16'sd250, 16'sd250, 8'd10, WIRING_UNUSED, SRC_REMOTE, ROLE_MASTER,
                DayStartRst, DayEndRst);
    tick_q.push_back(tick_of(10, 0, 0, 800, 100, 1, 0, 1, 0, 0, 1, 1));
    tick_q.push_back(tick_of(10, 0, 1, 900, 400, 1, 0, 1, 0, 0, 1, 1));
    settle();

    for (ph = 0; ph < RandPhases; ph++) begin
      case ($urandom_range(9))
        0: dsp = 16'sd32767;
        1: dsp = 16'h8000;
        default: dsp = 16'($urandom_range(300, 100));
      endcase
      case ($urandom_range(9))
        0: nsp = 16'sd32767;
        1: nsp = 16'h8000;
        default: nsp = 16'($urandom_range(300, 100));
      endcase
      case ($urandom_range(5))
        0: db = 8'd0;
        1: db = 8'd255;
        default: db = 8'($urandom_range(40));
      endcase
      wm = ($urandom_range(7) == 0) ? WIRING_UNUSED : 2'($urandom_range(2));
      ws = {5'($urandom_range(9, 4)), 8'($urandom_range(59))};
      we = {5'($urandom_range(21, 16)), 8'($urandom_range(59))};
      if ($urandom_range(3) == 0) begin
        wtmp = ws;
        ws = we;
        we = wtmp;
      end
      if ($urandom_range(5) == 0) ws = 13'($urandom);
      load_config(dsp, nsp, db, wm, 1'($urandom_range(1)),
                  ($urandom_range(3) == 0) ? ROLE_MASTER : ROLE_SLAVE, ws, we);
      steady <= (ph == RandPhases / 2);

      // Runs of ticks that hold near one temperature, so stages get time to age.
      n = 0;
      while (n < TicksPerPhase) begin
        seg = $urandom_range(10, 3);
        hr = $urandom_range(23);
        base = $urandom_range(1) ? int'(day_sp) : int'(night_sp);
        span = int'(band) + 20;
        aim = base + int'($urandom_range(2 * span)) - span;
        cmd_sp = $urandom_range(1);
        if ($urandom_range(40) == 0) run_ctr = 32'hFFFF_FF00 + $urandom_range(255);
        for (k = 0; k < seg && n < TicksPerPhase; k++) begin
          if ($urandom_range(5) == 0) begin
            noise = {$urandom, $urandom, $urandom, $urandom};
            tick_q.push_back(noise[$bits(tsrc_in_t)-1:0]);
          end else begin
            run_ctr += $urandom_range(150);
            tv = sat16(aim + int'($urandom_range(8)) - 4);
            tick_q.push_back(tick_of(hr, $urandom_range(59), $urandom_range(59), run_ctr,
                                     tv, 1'b1, tv, $urandom_range(15) != 0, cmd_sp, base,
                                     1'b1, $urandom_range(11) != 0));
          end
          n++;
        end
      end
      settle();
    end
    steady <= 1'b0;

    repeat (4) @(posedge clk);
    n_fail += relay_expect_q.size();
    $display("Covered %0d control ticks under %0d register settings, %0d results checked.",
             n_ticks, RandPhases + 4, n_results);
    $display("Reported calls: %0d cooling, %0d heating; %0d results held stage 2.",
             n_cool, n_heat, n_stage2);
    if (n_fail == 0) begin
      $display("thermostat_stage_relay_control verification clean");
    end else begin
      $display("thermostat_stage_relay_control verification failed");
    end
    $finish;
  end

endmodule
